@@ design/assert_macros.svh @@
// Assertion macros used by the ring top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ design/fssr_pkg.sv @@
package fssr_pkg;

   // Ring geometry
   localparam int NUM_SLOTS = 8;
   localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Field widths
   localparam int ACTION_W     = 3;
   localparam int SLOT_FIELD_W = 3;
   localparam int SEQ_W        = 32;
   localparam int TIME_W       = 64;
   localparam int ENTRY_W      = SEQ_W + TIME_W;

   // Request tdata layout: slot_index, frame_time, tolerance, closest, view_seq
   localparam int REQ_SLOT_LSB    = 0;
   localparam int REQ_TIME_LSB    = REQ_SLOT_LSB + SLOT_FIELD_W;
   localparam int REQ_TOL_LSB     = REQ_TIME_LSB + TIME_W;
   localparam int REQ_CLOSEST_BIT = REQ_TOL_LSB + TIME_W;
   localparam int REQ_VSEQ_LSB    = REQ_CLOSEST_BIT + 1;
   localparam int REQ_FIELDS_W    = REQ_VSEQ_LSB + SEQ_W;
   localparam int REQ_DATA_W      = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Response tdata layout: result_slot, result_seq, result_time
   localparam int RSP_FIELDS_W = SLOT_FIELD_W + SEQ_W + TIME_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ACQUIRE = 3'd0,
      ACT_COMMIT  = 3'd1,
      ACT_VIEW    = 3'd2,
      ACT_LOOKUP  = 3'd3,
      ACT_CHECK   = 3'd4
   } action_type;

   // Control from the sequencer to the lookup scan unit
   typedef struct packed {
      logic               start;      // clear best match, new lookup
      logic               data_valid; // RAM read data belongs to the scan
      logic [SLOT_AW-1:0] index;      // slot of that read data
   } scan_ctl_type;

   // Best match found by the scan unit
   typedef struct packed {
      logic               found;
      logic [SLOT_AW-1:0] slot;
      logic [SEQ_W-1:0]   seq;
      logic [TIME_W-1:0]  stamp;
   } scan_best_type;

endpackage

@@ design/fssr_ram.sv @@
module fssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fssr_scan.sv @@
module fssr_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  fssr_pkg::scan_ctl_type       ctl,
   input  logic [fssr_pkg::TIME_W-1:0]  frame_time,
   input  logic [fssr_pkg::TIME_W-1:0]  tolerance,
   input  logic                         closest,
   input  logic [fssr_pkg::SEQ_W-1:0]   rd_seq,
   input  logic [fssr_pkg::TIME_W-1:0]  rd_time,
   output fssr_pkg::scan_best_type      best
);
   import fssr_pkg::*;

   // Stage 1: distance and candidate flag of one slot
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cand_ff;
   logic [TIME_W-1:0]  s1_diff_ff;
   logic [SLOT_AW-1:0] s1_idx_ff;
   logic [SEQ_W-1:0]   s1_seq_ff;
   logic [TIME_W-1:0]  s1_time_ff;

   // Stage 2: running best match
   logic               found_ff, found_in;
   logic [SLOT_AW-1:0] best_idx_ff;
   logic [TIME_W-1:0]  best_dist_ff;
   logic [SEQ_W-1:0]   best_seq_ff;
   logic [TIME_W-1:0]  best_time_ff;

   logic [TIME_W:0]    fwd_diff;
   logic [TIME_W-1:0]  rev_diff;
   logic [TIME_W-1:0]  abs_diff;
   logic               take;

   // Absolute difference: borrow of the forward subtract picks the direction
   always_comb begin
      fwd_diff = {1'b0, frame_time} - {1'b0, rd_time};
      rev_diff = rd_time - frame_time;
      abs_diff = fwd_diff[TIME_W] ? rev_diff : fwd_diff[TIME_W-1:0];
   end

   // First mode keeps the first hit; closest mode needs a strictly smaller distance
   assign take = s1_valid_ff && s1_cand_ff && (s1_diff_ff <= tolerance) &&
                 (!found_ff || (closest && (s1_diff_ff < best_dist_ff)));

   always_comb begin
      s1_valid_in = ctl.data_valid && !ctl.start;
      found_in    = ctl.start ? 1'b0 : (found_ff || take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         found_ff    <= found_in;
      end
      // skip never-written (zero) and odd slots
      s1_cand_ff <= (rd_seq != '0) && !rd_seq[0];
      s1_diff_ff <= abs_diff;
      s1_idx_ff  <= ctl.index;
      s1_seq_ff  <= rd_seq;
      s1_time_ff <= rd_time;
      if (take) begin
         best_idx_ff  <= s1_idx_ff;
         best_dist_ff <= s1_diff_ff;
         best_seq_ff  <= s1_seq_ff;
         best_time_ff <= s1_time_ff;
      end
   end

   always_comb begin
      best.found = found_ff;
      best.slot  = best_idx_ff;
      best.seq   = best_seq_ff;
      best.stamp = best_time_ff;
   end

endmodule

@@ design/frame_slot_seqlock_ring_top.sv @@
// Channel | Direction | Handshake          | Payload
// req     | in        | req_tvalid/tready  | tuser action; tdata slot_index..view_seq
// rsp     | out       | rsp_tvalid/tready  | tuser ok; tdata result_slot..result_time
//
// Acquire, commit, view-latest and check-clean pass from request to response
// register through a RAM read, a read-modify-write and a load state.
// Lookup reads every slot in turn, drains the compare pipeline (DRAIN1,
// DRAIN2), picks the best match and loads it. Each ends back in idle.
// Reset is synchronous; per-slot written bits clear at once, so no RAM sweep.
// A new request is taken while an earlier response waits in the output register.
`include "assert_macros.svh"

module frame_slot_seqlock_ring_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot_index, frame_time, tolerance, closest, view_seq, zero pad
   input  logic [fssr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic [fssr_pkg::ACTION_W-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_slot, result_seq, result_time, zero pad
   output logic [fssr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // ok
   output logic [0:0]                        rsp_tuser
);
   import fssr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_SCAN, S_DRAIN1, S_DRAIN2, S_PICK, S_SEND
   } state_type;

   state_type               state_ff, state_in;
   action_type              act_ff, act_in;
   logic [SLOT_FIELD_W-1:0] idx_ff, idx_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic [TIME_W-1:0]       tol_ff, tol_in;
   logic                    closest_ff, closest_in;
   logic [SEQ_W-1:0]        vseq_ff, vseq_in;
   logic [SLOT_AW-1:0]      slot_ff, slot_in;
   logic [SLOT_AW-1:0]      wp_ff, wp_in;
   logic                    latest_valid_ff, latest_valid_in;
   logic [SLOT_AW-1:0]      latest_slot_ff, latest_slot_in;
   logic [NUM_SLOTS-1:0]    written_ff, written_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [SLOT_AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [SLOT_AW-1:0]      scan_cnt_ff, scan_cnt_in;
   logic                    res_ok_ff, res_ok_in;
   logic [SLOT_FIELD_W-1:0] res_slot_ff, res_slot_in;
   logic [SEQ_W-1:0]        res_seq_ff, res_seq_in;
   logic [TIME_W-1:0]       res_time_ff, res_time_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [RSP_FIELDS_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    ram_we;
   logic [SLOT_AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0]      ram_wdata;
   logic                    ram_re;
   logic [SLOT_AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]      ram_rdata;
   logic [SEQ_W-1:0]        rd_seq;
   logic [TIME_W-1:0]       rd_time;
   logic [SEQ_W-1:0]        seq_inc;
   logic                    idx_ok;
   logic                    req_fire;
   scan_ctl_type            scan_ctl;
   scan_best_type           scan_best;

   fssr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   fssr_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .frame_time (time_ff),
      .tolerance  (tol_ff),
      .closest    (closest_ff),
      .rd_seq     (rd_seq),
      .rd_time    (rd_time),
      .best       (scan_best)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Entries never written read as zero
   assign rd_seq  = rd_valid_ff ? ram_rdata[SEQ_W-1:0] : '0;
   assign rd_time = rd_valid_ff ? ram_rdata[ENTRY_W-1:SEQ_W] : '0;
   assign seq_inc = rd_seq + 1'b1;
   assign idx_ok  = (int'(idx_ff) < NUM_SLOTS);

   assign scan_ctl.start      = req_fire;
   assign scan_ctl.data_valid = rd_pend_ff;
   assign scan_ctl.index      = rd_idx_ff;

   // Sequencer and read-modify-write of one slot
   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      idx_in          = idx_ff;
      time_in         = time_ff;
      tol_in          = tol_ff;
      closest_in      = closest_ff;
      vseq_in         = vseq_ff;
      slot_in         = slot_ff;
      wp_in           = wp_ff;
      latest_valid_in = latest_valid_ff;
      latest_slot_in  = latest_slot_ff;
      written_in      = written_ff;
      rd_pend_in      = 1'b0;
      rd_idx_in       = rd_idx_ff;
      scan_cnt_in     = scan_cnt_ff;
      res_ok_in       = res_ok_ff;
      res_slot_in     = res_slot_ff;
      res_seq_in      = res_seq_ff;
      res_time_in     = res_time_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_ok_in       = rsp_ok_ff;
      rsp_data_in     = rsp_data_ff;
      ram_we          = 1'b0;
      ram_waddr       = slot_ff;
      ram_wdata       = {rd_time, seq_inc};
      ram_re          = 1'b0;
      ram_raddr       = scan_cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in      = action_type'(req_tuser);
               idx_in      = req_tdata[REQ_SLOT_LSB +: SLOT_FIELD_W];
               time_in     = req_tdata[REQ_TIME_LSB +: TIME_W];
               tol_in      = req_tdata[REQ_TOL_LSB +: TIME_W];
               closest_in  = req_tdata[REQ_CLOSEST_BIT];
               vseq_in     = req_tdata[REQ_VSEQ_LSB +: SEQ_W];
               scan_cnt_in = '0;
               state_in    = (action_type'(req_tuser) == ACT_LOOKUP) ? S_SCAN : S_READ;
            end
         end
         S_READ: begin
            ram_re = 1'b1;
            case (act_ff)
               ACT_ACQUIRE: ram_raddr = wp_ff;
               ACT_VIEW:    ram_raddr = latest_slot_ff;
               default:     ram_raddr = SLOT_AW'(idx_ff);
            endcase
            slot_in  = ram_raddr;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_ok_in   = 1'b0;
            res_slot_in = '0;
            res_seq_in  = '0;
            res_time_in = '0;
            case (act_ff)
               ACT_ACQUIRE: begin
                  ram_we      = 1'b1;
                  written_in[slot_ff] = 1'b1;
                  wp_in       = (wp_ff == SLOT_AW'(NUM_SLOTS - 1)) ? '0 : wp_ff + 1'b1;
                  res_ok_in   = 1'b1;
                  res_slot_in = SLOT_FIELD_W'(slot_ff);
                  res_seq_in  = seq_inc;
                  res_time_in = rd_time;
               end
               ACT_COMMIT: begin
                  if (idx_ok) begin
                     ram_we          = 1'b1;
                     ram_wdata       = {time_ff, seq_inc};
                     written_in[slot_ff] = 1'b1;
                     latest_valid_in = 1'b1;
                     latest_slot_in  = slot_ff;
                     res_ok_in       = 1'b1;
                     res_slot_in     = SLOT_FIELD_W'(slot_ff);
                     res_seq_in      = seq_inc;
                     res_time_in     = time_ff;
                  end
               end
               ACT_VIEW: begin
                  if (latest_valid_ff && !rd_seq[0]) begin
                     res_ok_in   = 1'b1;
                     res_slot_in = SLOT_FIELD_W'(slot_ff);
                     res_seq_in  = rd_seq;
                     res_time_in = rd_time;
                  end
               end
               ACT_CHECK: begin
                  if (idx_ok) begin
                     res_ok_in   = (rd_seq == vseq_ff) && !vseq_ff[0];
                     res_slot_in = SLOT_FIELD_W'(slot_ff);
                     res_seq_in  = rd_seq;
                     res_time_in = rd_time;
                  end
               end
               default: begin
                  res_ok_in = 1'b0;
               end
            endcase
            state_in = S_SEND;
         end
         S_SCAN: begin
            // one slot read per cycle
            ram_re     = 1'b1;
            ram_raddr  = scan_cnt_ff;
            rd_pend_in = 1'b1;
            rd_idx_in  = scan_cnt_ff;
            if (scan_cnt_ff == SLOT_AW'(NUM_SLOTS - 1)) begin
               state_in = S_DRAIN1;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         S_DRAIN1: begin
            state_in = S_DRAIN2;
         end
         S_DRAIN2: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            res_ok_in   = scan_best.found;
            res_slot_in = scan_best.found ? SLOT_FIELD_W'(scan_best.slot) : '0;
            res_seq_in  = scan_best.found ? scan_best.seq : '0;
            res_time_in = scan_best.found ? scan_best.stamp : '0;
            state_in    = S_SEND;
         end
         S_SEND: begin
            // move the result into the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_data_in  = {res_time_ff, res_seq_ff, res_slot_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rd_valid_in = written_ff[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         wp_ff           <= '0;
         latest_valid_ff <= 1'b0;
         latest_slot_ff  <= '0;
         written_ff      <= '0;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         wp_ff           <= wp_in;
         latest_valid_ff <= latest_valid_in;
         latest_slot_ff  <= latest_slot_in;
         written_ff      <= written_in;
         rd_pend_ff      <= rd_pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      act_ff      <= act_in;
      idx_ff      <= idx_in;
      time_ff     <= time_in;
      tol_ff      <= tol_in;
      closest_ff  <= closest_in;
      vseq_ff     <= vseq_in;
      slot_ff     <= slot_in;
      rd_valid_ff <= rd_valid_in;
      rd_idx_ff   <= rd_idx_in;
      scan_cnt_ff <= scan_cnt_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      res_seq_ff  <= res_seq_in;
      res_time_ff <= res_time_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_ok_ff;
   assign rsp_tdata    = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

   // RAM writes only in the modify cycle, never beside a read of the next request
   `ASSERT_IMPLIES(a_write_in_exec, clock, reset, ram_we, state_ff == S_EXEC)
   // A taken request always leaves the idle state
   `ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)
   // Written bits only ever get set
   `ASSERT_NEXT(a_written_grows, clock, reset, 1'b1,
                (written_ff & $past(written_ff)) == $past(written_ff))
   // Leaving the send state loads the output register
   `ASSERT_NEXT(a_send_loads, clock, reset,
                (state_ff == S_SEND) && (!rsp_valid_ff || rsp_tready), rsp_valid_ff)

endmodule

@@ sim/frame_slot_seqlock_ring_top_tb.sv @@
module frame_slot_seqlock_ring_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fssr_pkg::*;

   // Undefined action code, not part of the package enum
   localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [SEQ_W-1:0]  SEQ_MAX  = '1;

   // Response tdata layout
   localparam int RSP_SEQ_LSB  = SLOT_FIELD_W;
   localparam int RSP_TIME_LSB = SLOT_FIELD_W + SEQ_W;

   localparam int RANDOM_REQUESTS = 800;

   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TIME_W-1:0]       stamp;
      logic [TIME_W-1:0]       tol;
      logic                    closest;
      logic [SEQ_W-1:0]        vseq;
   } slot_req_type;

   typedef struct packed {
      logic                    ok;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [SEQ_W-1:0]        seq;
      logic [TIME_W-1:0]       stamp;
   } slot_view_type;

   typedef struct packed {
      slot_req_type  req;
      logic          known;
      slot_view_type want;
   } dir_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [ACTION_W-1:0]     req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [0:0]              rsp_tuser;

   // Shadow copy of the slot metadata
   logic [SEQ_W-1:0]  shadow_seq [NUM_SLOTS];
   logic [TIME_W-1:0] slot_stamp [NUM_SLOTS];
   int                ring_wp;
   logic              latest_set;
   int                latest_idx;

   slot_view_type slot_views_due [$];
   dir_row_type   dir_rows [$];
   int          failures = 0;
   int          requests_sent = 0;
   bit          quiet = 1'b0;
   logic [TIME_W-1:0] stamp_anchor;

   frame_slot_seqlock_ring_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [TIME_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic slot_view_type slot_snapshot(logic ok, int s);
      slot_view_type v;
      v.ok    = ok;
      v.slot  = SLOT_FIELD_W'(s);
      v.seq   = shadow_seq[s];
      v.stamp = slot_stamp[s];
      return v;
   endfunction

   // Apply one request to the shadow state, return the slot view it yields
   function automatic slot_view_type apply_slot_action(slot_req_type r);
      slot_view_type     res;
      int                s;
      logic              hit;
      int                pick;
      logic [TIME_W-1:0] diff;
      logic [TIME_W-1:0] best_gap;
      res      = '0;
      hit      = 1'b0;
      pick     = 0;
      best_gap = '0;
      s        = int'(r.slot);
      case (r.action)
         ACT_ACQUIRE: begin
            s = ring_wp;
            ring_wp = (ring_wp + 1) % NUM_SLOTS;
            shadow_seq[s] = shadow_seq[s] + 1;
            res = slot_snapshot(1'b1, s);
         end
         ACT_COMMIT: begin
            if (s < NUM_SLOTS) begin
               slot_stamp[s] = r.stamp;
               shadow_seq[s] = shadow_seq[s] + 1;
               latest_idx    = s;
               latest_set    = 1'b1;
               res = slot_snapshot(1'b1, s);
            end
         end
         ACT_VIEW: begin
            if (latest_set && !shadow_seq[latest_idx][0])
               res = slot_snapshot(1'b1, latest_idx);
         end
         ACT_LOOKUP: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               // never written or mid-write slots are skipped
               if (shadow_seq[i] == '0 || shadow_seq[i][0])
                  continue;
               diff = (r.stamp > slot_stamp[i]) ? r.stamp - slot_stamp[i]
                                                : slot_stamp[i] - r.stamp;
               if (diff > r.tol)
                  continue;
               if (!r.closest) begin
                  hit  = 1'b1;
                  pick = i;
                  break;
               end
               if (!hit || diff < best_gap) begin
                  hit      = 1'b1;
                  pick     = i;
                  best_gap = diff;
               end
            end
            if (hit)
               res = slot_snapshot(1'b1, pick);
         end
         ACT_CHECK: begin
            if (s < NUM_SLOTS)
               res = slot_snapshot(shadow_seq[s] == r.vseq && !r.vseq[0], s);
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   task automatic add_row(input logic [ACTION_W-1:0] act, input logic [2:0] sl,
                          input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] tl,
                          input logic cl, input logic [SEQ_W-1:0] vs,
                          input logic known, input slot_view_type want);
      dir_row_type row;
      row.req  = '{act, sl, st, tl, cl, vs};
      row.known = known;
      row.want  = want;
      dir_rows.push_back(row);
   endtask

   // Drive one request; queue its expected view once it is accepted
   task automatic send_slot_request(input slot_req_type r, input logic known = 1'b0,
                                    input slot_view_type want = '0);
      logic [REQ_DATA_W-1:0] d;
      slot_view_type         pred;
      d = '0;
      d[REQ_SLOT_LSB +: SLOT_FIELD_W] = r.slot;
      d[REQ_TIME_LSB +: TIME_W]       = r.stamp;
      d[REQ_TOL_LSB +: TIME_W]        = r.tol;
      d[REQ_CLOSEST_BIT]              = r.closest;
      d[REQ_VSEQ_LSB +: SEQ_W]        = r.vseq;
      while (!quiet && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= r.action;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pred = apply_slot_action(r);
      slot_views_due.push_back(known ? want : pred);
      requests_sent++;
   endtask

   // Timestamps mostly march forward so lookups find neighbors
   function automatic logic [TIME_W-1:0] next_stamp();
      if ($urandom_range(9) == 0)
         return rand64();
      stamp_anchor = stamp_anchor + TIME_W'($urandom_range(1, 3000));
      return stamp_anchor;
   endfunction

   function automatic logic [TIME_W-1:0] pick_tol();
      case ($urandom_range(5))
         0:       return '0;
         1:       return TIME_MAX;
         2:       return rand64();
         default: return TIME_W'($urandom_range(0, 500));
      endcase
   endfunction

   // Receiver stalls
   always @(posedge clock)
      rsp_tready <= quiet || ($urandom_range(99) >= 36);

   // Response checker
   always @(posedge clock) begin
      slot_view_type got;
      slot_view_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok    = rsp_tuser[0];
         got.slot  = rsp_tdata[0 +: SLOT_FIELD_W];
         got.seq   = rsp_tdata[RSP_SEQ_LSB +: SEQ_W];
         got.stamp = rsp_tdata[RSP_TIME_LSB +: TIME_W];
         if (slot_views_due.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = slot_views_due.pop_front();
            if (got.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, got.ok);
               failures++;
            end
            if (got.slot !== want.slot) begin
               $error("result_slot: expected %0d, got %0d", want.slot, got.slot);
               failures++;
            end
            if (got.seq !== want.seq) begin
               $error("result_seq: expected %0h, got %0h", want.seq, got.seq);
               failures++;
            end
            if (got.stamp !== want.stamp) begin
               $error("result_time: expected %0h, got %0h", want.stamp, got.stamp);
               failures++;
            end
         end
      end
   end

   initial begin
      slot_req_type r;
      int        k;
      int        roll;
      int        off;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_seq[i] = '0;
         slot_stamp[i] = '0;
      end
      ring_wp      = 0;
      latest_set   = 1'b0;
      latest_idx   = 0;
      stamp_anchor = rand64();

      // Directed table: known results typed in, the rest predicted
      add_row(ACT_VIEW,    0, 0, 0, 0, 0, 1, '0);                // no latest yet
      add_row(ACT_LOOKUP,  0, 0, TIME_MAX, 1, 0, 1, '0);         // nothing written
      add_row(ACT_CHECK,   0, 0, 0, 0, 0, 1, '{1'b1, 3'd0, 32'd0, 64'd0});
      add_row(ACT_RSVD7,   7, TIME_MAX, TIME_MAX, 1, SEQ_MAX, 1, '0);
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 1, '{1'b1, 3'd0, 32'd1, 64'd0});
      add_row(ACT_VIEW,    0, 0, 0, 0, 0, 1, '0);                // acquired, not committed
      add_row(ACT_COMMIT,  0, TIME_MAX, 0, 0, 0, 1, '{1'b1, 3'd0, 32'd2, TIME_MAX});
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 1, '{1'b1, 3'd1, 32'd1, 64'd0});
      add_row(ACT_COMMIT,  1, 0, 0, 0, 0, 1, '{1'b1, 3'd1, 32'd2, 64'd0});
      add_row(ACT_COMMIT,  7, 1000, 0, 0, 0, 0, '0);             // commit on never-acquired slot 7
      add_row(ACT_VIEW,    0, 0, 0, 0, 0, 1, '0);                // latest slot odd
      add_row(ACT_LOOKUP,  0, 0, 0, 0, 0, 0, '0);                // exact, tolerance zero
      add_row(ACT_LOOKUP,  0, TIME_MAX, TIME_MAX, 1, 0, 0, '0);
      add_row(ACT_LOOKUP,  0, 0, TIME_MAX, 0, 0, 0, '0);         // widest difference
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0, '0);
      add_row(ACT_COMMIT,  2, 50, 0, 0, 0, 0, '0);
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0, '0);
      add_row(ACT_COMMIT,  3, 150, 0, 0, 0, 0, '0);
      add_row(ACT_LOOKUP,  0, 100, 50, 1, 0, 0, '0);             // tie, low index wins
      add_row(ACT_LOOKUP,  0, 140, 100, 0, 0, 0, '0);            // first by index
      add_row(ACT_LOOKUP,  0, 140, 100, 1, 0, 0, '0);            // closest
      add_row(ACT_CHECK,   3, 0, 0, 0, 2, 0, '0);                // clean
      add_row(ACT_CHECK,   7, 0, 0, 0, 1, 0, '0);                // equal but odd
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0, '0);
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0, '0);
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0, '0);
      add_row(ACT_ACQUIRE, 0, 0, 0, 0, 0, 0, '0);                // acquire on odd slot

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_rows.size(); i++)
         send_slot_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);

      // Random traffic, mostly acquire/commit pairs and lookups near stored times
      while (requests_sent < RANDOM_REQUESTS) begin
         quiet = (requests_sent >= 300 && requests_sent < 450);
         r = '{ACT_ACQUIRE, 3'($urandom()), rand64(), rand64(), 1'($urandom()),
                $urandom()};
         roll = $urandom_range(99);
         if (roll < 40) begin
            k = ring_wp;
            send_slot_request(r);
            r.action = ACT_COMMIT;
            r.slot   = SLOT_FIELD_W'(k);
            r.stamp  = next_stamp();
            send_slot_request(r);
         end else if (roll < 60) begin
            k = $urandom_range(NUM_SLOTS - 1);
            off = $urandom_range(0, 400);
            r.action  = ACT_LOOKUP;
            r.stamp   = $urandom_range(1) ? slot_stamp[k] + TIME_W'(off)
                                          : slot_stamp[k] - TIME_W'(off);
            r.tol     = pick_tol();
            send_slot_request(r);
         end else if (roll < 70) begin
            r.action = ACT_VIEW;
            send_slot_request(r);
         end else if (roll < 85) begin
            r.action = ACT_CHECK;
            case ($urandom_range(5))
               0:       r.vseq = shadow_seq[r.slot] + 1;
               1:       r.vseq = shadow_seq[r.slot] - 1;
               2:       r.vseq = $urandom();
               default: r.vseq = shadow_seq[r.slot];
            endcase
            send_slot_request(r);
         end else begin
            // noise: any code, including undefined ones and stray commits
            r.action = ACTION_W'($urandom_range(ACT_ACQUIRE, ACT_RSVD7));
            send_slot_request(r);
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (slot_views_due.size() != 0)
         @(posedge clock);
      repeat (4 * NUM_SLOTS) @(posedge clock);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
